@@ src/dcsw_pkg.sv @@
// Shared types and constants for the DMA channel stall watchdog.
// No dependencies; imported by every module of the block except dcsw_ram.
package dcsw_pkg;

    localparam int PTR_W      = 32;
    localparam int QUEUE_W    = 9;
    localparam int COUNT_W    = 8;
    localparam int THRESH_W   = 8;
    localparam int CHAN_W     = 2;
    localparam int OUT_DEPTH  = 3;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 8'hFF;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd3;

    typedef enum logic
    {
        DIR_TX = 1'b0,
        DIR_RX = 1'b1
    } dir_t;

    typedef struct packed
    {
        dir_t                dir;
        logic                busy;
        logic [PTR_W-1:0]    ptr;
        logic [QUEUE_W-1:0]  queue;
    } sample_t;

    typedef struct packed
    {
        logic [PTR_W-1:0]    ptr;
        logic [QUEUE_W-1:0]  queue;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic                stalled;
        logic [COUNT_W-1:0]  count;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // sample in the read-modify-write stage
    typedef struct packed
    {
        logic    valid;
        logic    ignore;
        logic    hit;
        sample_t sample;
    } rmw_ctl_t;

endpackage

@@ src/dcsw_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module dcsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/dcsw_update.sv @@
// Read-modify-write stage: stuck detection, count update, write-back.
// Depends on dcsw_pkg; forwards its own last write to cover RAM read-during-write.
module dcsw_update
    import dcsw_pkg::*;
#(
    parameter int AW = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rmw_ctl_t            ctl,
    input  logic [AW-1:0]       addr,
    input  logic [ENTRY_W-1:0]  rd_data,
    input  logic [THRESH_W-1:0] threshold,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [ENTRY_W-1:0]  wr_data,
    output logic                res_valid,
    output result_t             res
);

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    entry_t        fwd_data_reg;
    entry_t        prev;
    entry_t        next_entry;
    logic          stuck;
    logic [COUNT_W-1:0] count;

    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == addr)
        begin
            prev = fwd_data_reg;
        end
        else if (ctl.hit)
        begin
            prev = entry_t'(rd_data);
        end
        else
        begin
            prev = '0;
        end

        stuck = (ctl.sample.ptr == prev.ptr) && ctl.sample.busy;
        if (ctl.sample.dir == DIR_RX)
        begin
            stuck = stuck && (ctl.sample.queue != '0) && (ctl.sample.queue == prev.queue);
        end

        if (!stuck)
        begin
            count = '0;
        end
        else if (prev.count != COUNT_MAX)
        begin
            count = prev.count + 1'b1;
        end
        else
        begin
            count = prev.count;
        end

        next_entry.ptr   = ctl.sample.ptr;
        next_entry.queue = (ctl.sample.dir == DIR_RX) ? ctl.sample.queue : prev.queue;
        next_entry.count = count;

        if (ctl.ignore)
        begin
            res = '0;
        end
        else
        begin
            res.stalled = stuck && (count >= threshold);
            res.count   = count;
        end
    end

    assign wr_en     = ctl.valid && !ctl.ignore;
    assign wr_addr   = addr;
    assign wr_data   = next_entry;
    assign res_valid = ctl.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= addr;
            fwd_data_reg <= next_entry;
        end
    end

    a_stall_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.stalled |-> res.count != '0)
        else $error("stall flagged with zero count");

    a_ignore_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && ctl.ignore |-> !wr_en && !res.stalled && res.count == '0)
        else $error("ignored sample touched state or result");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fwd_valid_reg && fwd_addr_reg == $past(addr))
        else $error("forward register lost last write");

endmodule

@@ src/dcsw_out_fifo.sv @@
// Small result queue that decouples the update stage from the output stall.
// Depends on dcsw_pkg.
module dcsw_out_fifo
    import dcsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output result_t    pop_data,
    output logic [1:0] count
);

    result_t    mem_reg [OUT_DEPTH];
    logic [1:0] head_reg;
    logic [1:0] tail_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = mem_reg[head_reg];
    assign count     = count_reg;

    function automatic logic [1:0] wrap_inc(input logic [1:0] p);
        return (p == 2'(OUT_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= wrap_inc(tail_reg);
            end
            if (pop)
            begin
                head_reg <= wrap_inc(head_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != 2'(OUT_DEPTH))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(OUT_DEPTH))
        else $error("result queue count out of range");

endmodule

@@ src/dma_channel_stall_watchdog_top.sv @@
// DMA channel stall watchdog, top level: stream ports, threshold register, state RAM.
// Depends on dcsw_pkg, dcsw_ram, dcsw_update and dcsw_out_fifo.
//
// Takes one channel sample per clock while input ready is high and returns one result
// per sample through the update stage register and the result queue. Per-pair state
// (pointer, queue level, stuck count) lives in one RAM of 2*CHANNELS entries with a
// registered read; the cycle after the read computes and writes the entry back, with
// its last write forwarded so that back-to-back samples of the same pair see current
// state. Valid bits per entry make the RAM read as zero after reset, so no clearing
// pass is needed. A three-deep result queue absorbs output stalls; input ready drops
// once the queue and the update stage together hold three results. The threshold
// register resets to 3 and should be written only while idle.
module dma_channel_stall_watchdog_top
    import dcsw_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [THRESH_W-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [1:0] channel, [33:2] ring_pointer, [34] busy_req, [43:35] queue_level
    input  logic [47:0]         s_axis_tdata,
    // [0] direction
    input  logic [0:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] stalled, [8:1] stuck_count
    output logic [15:0]         m_axis_tdata
);

    localparam int DEPTH = 2 * CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    logic [THRESH_W-1:0] threshold_reg;
    logic [DEPTH-1:0]    valid_reg;
    rmw_ctl_t            s1_reg;
    rmw_ctl_t            s1_next;
    logic [AW-1:0]       s1_addr_reg;

    logic [CHAN_W-1:0]   in_chan;
    logic [AW-1:0]       in_addr;
    logic                in_accept;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                res_valid;
    result_t             res;
    result_t             out_res;
    logic [1:0]          fifo_count;

    assign in_chan   = s_axis_tdata[1:0];
    assign in_addr   = AW'(32'(s_axis_tuser[0]) * CHANNELS + 32'(in_chan));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = ({1'b0, fifo_count} + {2'b0, s1_reg.valid}) < 3'(OUT_DEPTH);

    always_comb
    begin
        s1_next.valid        = in_accept;
        s1_next.ignore       = 32'(in_chan) >= 32'(CHANNELS);
        s1_next.hit          = valid_reg[in_addr];
        s1_next.sample.dir   = dir_t'(s_axis_tuser[0]);
        s1_next.sample.ptr   = s_axis_tdata[33:2];
        s1_next.sample.busy  = s_axis_tdata[34];
        s1_next.sample.queue = s_axis_tdata[43:35];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            valid_reg     <= '0;
            s1_reg        <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= in_addr;
        end
    end

    dcsw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    dcsw_update #(
        .AW (AW)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s1_reg),
        .addr      (s1_addr_reg),
        .rd_data   (rd_data),
        .threshold (threshold_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res)
    );

    dcsw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (out_res),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {{(16 - RESULT_W){1'b0}}, out_res.count, out_res.stalled};

    a_stage_only_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid |-> $past(in_accept))
        else $error("update stage active without an accepted transaction");

    a_ready_bounds_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> fifo_count != 2'(OUT_DEPTH))
        else $error("input ready while result queue full");

    a_written_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(wr_addr)])
        else $error("written entry not marked valid");

endmodule

@@ sim/tb_dma_channel_stall_watchdog_top.sv @@
// Self-checking testbench for dma_channel_stall_watchdog_top: stream driver, monitor, scoreboard.
// Per-pair stuck-count predictor checks every result; directed, burst and noise samples.
// Depends on dcsw_pkg and the RTL under src.
module tb_dma_channel_stall_watchdog_top
    import dcsw_pkg::*;
;

    localparam int NUM_CHANNELS = 4;
    localparam int PAIRS        = 2 * NUM_CHANNELS;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct
    {
        dir_t                dir;
        logic [CHAN_W-1:0]   chan;
        logic [PTR_W-1:0]    ptr;
        logic                busy;
        logic [QUEUE_W-1:0]  queue;
    } chan_sample_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wen = 1'b0;
    logic [THRESH_W-1:0] cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;

    // predictor state
    logic [PTR_W-1:0]    last_ptr [PAIRS];
    logic [QUEUE_W-1:0]  last_queue [PAIRS];
    logic [COUNT_W-1:0]  stuck_run [PAIRS];
    logic [THRESH_W-1:0] stall_thr = THRESHOLD_RESET;

    // stimulus-side view of the pair state, used to build stuck sequences
    logic [PTR_W-1:0]    sent_ptr [PAIRS];
    logic [QUEUE_W-1:0]  sent_queue [PAIRS];

    chan_sample_t pending_samples [$];
    result_t      expected_results [$];
    chan_sample_t cur_sample;

    logic in_fire = 1'b0;
    int   queued_n = 0;
    int   accepted_n = 0;
    int   mismatch_n = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    dma_channel_stall_watchdog_top #(
        .CHANNELS (NUM_CHANNELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t predict_watchdog(chan_sample_t s);
        int      slot;
        logic    stuck;
        result_t r;
        r = '0;
        if (int'(s.chan) >= NUM_CHANNELS)
            return r;
        slot = int'(s.dir) * NUM_CHANNELS + int'(s.chan);
        stuck = (s.ptr == last_ptr[slot]) && s.busy;
        if (s.dir == DIR_RX)
            stuck = stuck && (s.queue != '0) && (s.queue == last_queue[slot]);
        if (!stuck)
            r.count = '0;
        else if (stuck_run[slot] == COUNT_MAX)
            r.count = COUNT_MAX;
        else
            r.count = stuck_run[slot] + 1'b1;
        stuck_run[slot] = r.count;
        last_ptr[slot] = s.ptr;
        if (s.dir == DIR_RX)
            last_queue[slot] = s.queue;
        r.stalled = stuck && (r.count >= stall_thr);
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin : drive_samples
        chan_sample_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                cur_sample    <= nxt;
                s_axis_tdata  <= {4'b0, nxt.queue, nxt.busy, nxt.ptr, nxt.chan};
                s_axis_tuser  <= nxt.dir;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge clk)
        m_axis_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);

    // monitor and scoreboard
    always @(posedge clk)
    begin : watch_streams
        result_t got;
        result_t want;
        if (rst_n)
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_watchdog(cur_sample));
                accepted_n++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.stalled = m_axis_tdata[0];
                got.count   = m_axis_tdata[8:1];
                if (expected_results.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("unexpected transaction: stalled %0b count %0d",
                                 got.stalled, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.stalled !== want.stalled || got.count !== want.count)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display("mismatch: stalled exp %0b got %0b, count exp %0d got %0d",
                                     want.stalled, got.stalled, want.count, got.count);
                    end
                end
            end
        end
    end

    task automatic push_sample(dir_t d, int c, logic [PTR_W-1:0] p, logic b,
                               logic [QUEUE_W-1:0] q);
        chan_sample_t s;
        int           slot;
        s.dir   = d;
        s.chan  = CHAN_W'(c);
        s.ptr   = p;
        s.busy  = b;
        s.queue = q;
        slot = int'(d) * NUM_CHANNELS + c;
        sent_ptr[slot] = p;
        if (d == DIR_RX)
            sent_queue[slot] = q;
        pending_samples.push_back(s);
        queued_n++;
    endtask

    function automatic logic [PTR_W-1:0] rand_ptr();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // bursts on one pair, mostly stuck, with some pure noise bursts
    task automatic add_bursts(int n);
        int                 made;
        int                 len;
        int                 c;
        int                 slot;
        dir_t               d;
        logic               noise;
        logic [PTR_W-1:0]   p;
        logic [QUEUE_W-1:0] q;
        made = 0;
        while (made < n)
        begin
            d = dir_t'($urandom_range(1));
            c = $urandom_range(NUM_CHANNELS - 1);
            slot = int'(d) * NUM_CHANNELS + c;
            len = $urandom_range(1, 12);
            noise = ($urandom_range(99) < 20);
            for (int i = 0; i < len && made < n; i++)
            begin
                if (noise)
                begin
                    push_sample(d, c, rand_ptr(), 1'($urandom_range(1)),
                                QUEUE_W'($urandom_range(511)));
                end
                else
                begin
                    p = ($urandom_range(99) < 8) ? rand_ptr() : sent_ptr[slot];
                    if (d == DIR_TX)
                        q = QUEUE_W'($urandom_range(511));
                    else if (sent_queue[slot] == '0 || $urandom_range(99) < 8)
                        q = QUEUE_W'($urandom_range(1, 511));
                    else
                        q = sent_queue[slot];
                    push_sample(d, c, p, ($urandom_range(99) < 92), q);
                end
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_n != queued_n || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THRESH_W-1:0] v);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = v;
        stall_thr = v;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        logic [PTR_W-1:0]   sat_ptr;
        logic [QUEUE_W-1:0] sat_queue;
        for (int k = 0; k < PAIRS; k++)
        begin
            last_ptr[k]   = '0;
            last_queue[k] = '0;
            stuck_run[k]  = '0;
            sent_ptr[k]   = '0;
            sent_queue[k] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        set_idling(10, 68);

        // reset threshold; transmit run up to stall, then busy drop
        repeat (4) push_sample(DIR_TX, 0, '0, 1'b1, '0);
        push_sample(DIR_TX, 0, '0, 1'b0, '0);
        // transmit ignores queue level
        push_sample(DIR_TX, 1, '1, 1'b1, '1);
        push_sample(DIR_TX, 1, '1, 1'b1, 9'h0AA);
        push_sample(DIR_TX, 1, '1, 1'b1, '1);
        push_sample(DIR_TX, 1, '1, 1'b1, '0);
        // receive: zero queue never stuck, then a stuck run
        push_sample(DIR_RX, 2, '0, 1'b1, '0);
        push_sample(DIR_RX, 2, '0, 1'b1, '0);
        repeat (4) push_sample(DIR_RX, 2, '0, 1'b1, '1);
        // receive: queue change, pointer change, busy drop each clear
        push_sample(DIR_RX, 3, 32'h1234_5678, 1'b1, 9'd5);
        push_sample(DIR_RX, 3, 32'h1234_5678, 1'b1, 9'd5);
        push_sample(DIR_RX, 3, 32'h1234_5678, 1'b1, 9'd6);
        push_sample(DIR_RX, 3, 32'hEDCB_A987, 1'b1, 9'd6);
        push_sample(DIR_RX, 3, 32'hEDCB_A987, 1'b0, 9'd6);
        // earlier pair keeps its count; transmit and receive pairs are separate
        push_sample(DIR_RX, 2, '0, 1'b1, '1);
        push_sample(DIR_TX, 3, '0, 1'b1, '0);
        push_sample(DIR_TX, 3, 32'h1234_5678, 1'b1, '0);
        add_bursts(180);
        wait_idle();

        write_threshold(8'd1);
        add_bursts(160);
        wait_idle();

        set_idling(68, 10);
        write_threshold(8'd255);
        sat_ptr   = $urandom;
        sat_queue = QUEUE_W'($urandom_range(1, 511));
        repeat (262) push_sample(DIR_RX, 1, sat_ptr, 1'b1, sat_queue);
        add_bursts(60);
        wait_idle();

        write_threshold(8'd0);
        add_bursts(120);
        wait_idle();

        set_idling(0, 0);
        write_threshold(THRESH_W'($urandom_range(2, 254)));
        add_bursts(150);
        @(posedge clk);
        hold_req = 1'b1;
        while (accepted_n != queued_n || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_n == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
